[sv/kf2_pkg.sv]
// kf2_pkg: shared types, operand map, microprogram and saturation helper
// for the two-state Kalman filter core. No dependencies.
package kf2_pkg;

  // divider geometry: numerator 2|adj|*2^24 + |det|, denominator 2|det|
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 43;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef struct packed {
    logic signed [31:0] meas_angle;
    logic signed [31:0] meas_rate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] est_angle;
    logic signed [31:0] est_rate;
    logic               singular;
    logic               saturated;
  } out_t;

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_RUN, ST_OUT} state_t;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_DOT, OP_DET, OP_DIV, OP_END} op_t;

  // operand index: bit 5 set selects scratch memory, else flop sources
  typedef logic [5:0] ix_t;
  typedef logic [5:0] pc_t;

  localparam ix_t IX_F00  = 6'd0;
  localparam ix_t IX_F01  = 6'd1;
  localparam ix_t IX_F10  = 6'd2;
  localparam ix_t IX_F11  = 6'd3;
  localparam ix_t IX_QA   = 6'd4;
  localparam ix_t IX_QR   = 6'd5;
  localparam ix_t IX_RA   = 6'd6;
  localparam ix_t IX_RR   = 6'd7;
  localparam ix_t IX_Y0   = 6'd8;
  localparam ix_t IX_Y1   = 6'd9;
  localparam ix_t IX_ZERO = 6'd10;
  localparam ix_t IX_ONE  = 6'd11;
  localparam ix_t IX_X0   = 6'd12;
  localparam ix_t IX_X1   = 6'd13;
  localparam ix_t IX_P0   = 6'd32;
  localparam ix_t IX_P1   = 6'd33;
  localparam ix_t IX_P2   = 6'd34;
  localparam ix_t IX_P3   = 6'd35;
  localparam ix_t IX_S0   = 6'd36;
  localparam ix_t IX_S3   = 6'd37;
  localparam ix_t IX_INV0 = 6'd38;  // reused for I - K
  localparam ix_t IX_INV1 = 6'd39;
  localparam ix_t IX_INV2 = 6'd40;
  localparam ix_t IX_INV3 = 6'd41;
  localparam ix_t IX_K0   = 6'd42;
  localparam ix_t IX_K1   = 6'd43;
  localparam ix_t IX_K2   = 6'd44;
  localparam ix_t IX_K3   = 6'd45;
  localparam ix_t IX_T0   = 6'd46;
  localparam ix_t IX_T1   = 6'd47;
  localparam ix_t IX_T2   = 6'd48;
  localparam ix_t IX_T3   = 6'd49;
  localparam ix_t IX_U0   = 6'd50;
  localparam ix_t IX_U1   = 6'd51;
  localparam ix_t IX_U2   = 6'd52;
  localparam ix_t IX_U3   = 6'd53;
  localparam ix_t IX_E0   = 6'd54;
  localparam ix_t IX_E1   = 6'd55;
  localparam ix_t IX_XU0  = 6'd56;
  localparam ix_t IX_XU1  = 6'd57;
  localparam ix_t IX_TMP  = 6'd58;

  localparam logic [3:0] CFG_F00 = 4'd0;
  localparam logic [3:0] CFG_F01 = 4'd1;
  localparam logic [3:0] CFG_F10 = 4'd2;
  localparam logic [3:0] CFG_F11 = 4'd3;
  localparam logic [3:0] CFG_QA  = 4'd4;
  localparam logic [3:0] CFG_QR  = 4'd5;
  localparam logic [3:0] CFG_RA  = 4'd6;
  localparam logic [3:0] CFG_RR  = 4'd7;

  typedef struct packed {
    op_t  op;
    logic neg;   // divide: negate the adjugate entry
    ix_t  dst;
    ix_t  a;
    ix_t  b;
    ix_t  c;
    ix_t  d;
  } instr_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'sh80000000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

  function automatic instr_t mk(input op_t op, input logic neg, input ix_t dst,
                                input ix_t a, input ix_t b, input ix_t c, input ix_t d);
    instr_t r;
    r.op  = op;
    r.neg = neg;
    r.dst = dst;
    r.a   = a;
    r.b   = b;
    r.c   = c;
    r.d   = d;
    return r;
  endfunction

  // one filter step; add/sub use a and b, dot is sat(rnd(a*b) + rnd(c*d))
  function automatic instr_t prog_rom(input pc_t pc);
    instr_t r;
    unique case (pc)
      6'd0:  r = mk(OP_ADD, 1'b0, IX_S0,   IX_P0,   IX_RA,   IX_ZERO, IX_ZERO);
      6'd1:  r = mk(OP_ADD, 1'b0, IX_S3,   IX_P3,   IX_RR,   IX_ZERO, IX_ZERO);
      6'd2:  r = mk(OP_DET, 1'b0, IX_TMP,  IX_S0,   IX_S3,   IX_P1,   IX_P2);
      6'd3:  r = mk(OP_DIV, 1'b0, IX_INV0, IX_S3,   IX_ZERO, IX_ZERO, IX_ZERO);
      6'd4:  r = mk(OP_DIV, 1'b1, IX_INV1, IX_P1,   IX_ZERO, IX_ZERO, IX_ZERO);
      6'd5:  r = mk(OP_DIV, 1'b1, IX_INV2, IX_P2,   IX_ZERO, IX_ZERO, IX_ZERO);
      6'd6:  r = mk(OP_DIV, 1'b0, IX_INV3, IX_S0,   IX_ZERO, IX_ZERO, IX_ZERO);
      6'd7:  r = mk(OP_DOT, 1'b0, IX_K0,   IX_P0,   IX_INV0, IX_P1,   IX_INV2);
      6'd8:  r = mk(OP_DOT, 1'b0, IX_K1,   IX_P0,   IX_INV1, IX_P1,   IX_INV3);
      6'd9:  r = mk(OP_DOT, 1'b0, IX_K2,   IX_P2,   IX_INV0, IX_P3,   IX_INV2);
      6'd10: r = mk(OP_DOT, 1'b0, IX_K3,   IX_P2,   IX_INV1, IX_P3,   IX_INV3);
      6'd11: r = mk(OP_SUB, 1'b0, IX_INV0, IX_ONE,  IX_K0,   IX_ZERO, IX_ZERO);
      6'd12: r = mk(OP_SUB, 1'b0, IX_INV1, IX_ZERO, IX_K1,   IX_ZERO, IX_ZERO);
      6'd13: r = mk(OP_SUB, 1'b0, IX_INV2, IX_ZERO, IX_K2,   IX_ZERO, IX_ZERO);
      6'd14: r = mk(OP_SUB, 1'b0, IX_INV3, IX_ONE,  IX_K3,   IX_ZERO, IX_ZERO);
      6'd15: r = mk(OP_DOT, 1'b0, IX_T0,   IX_P0,   IX_INV0, IX_P1,   IX_INV2);
      6'd16: r = mk(OP_DOT, 1'b0, IX_T1,   IX_P0,   IX_INV1, IX_P1,   IX_INV3);
      6'd17: r = mk(OP_DOT, 1'b0, IX_T2,   IX_P2,   IX_INV0, IX_P3,   IX_INV2);
      6'd18: r = mk(OP_DOT, 1'b0, IX_T3,   IX_P2,   IX_INV1, IX_P3,   IX_INV3);
      6'd19: r = mk(OP_DOT, 1'b0, IX_U0,   IX_F00,  IX_T0,   IX_F01,  IX_T2);
      6'd20: r = mk(OP_DOT, 1'b0, IX_U1,   IX_F00,  IX_T1,   IX_F01,  IX_T3);
      6'd21: r = mk(OP_DOT, 1'b0, IX_U2,   IX_F10,  IX_T0,   IX_F11,  IX_T2);
      6'd22: r = mk(OP_DOT, 1'b0, IX_U3,   IX_F10,  IX_T1,   IX_F11,  IX_T3);
      6'd23: r = mk(OP_DOT, 1'b0, IX_TMP,  IX_U0,   IX_F00,  IX_U1,   IX_F01);
      6'd24: r = mk(OP_ADD, 1'b0, IX_P0,   IX_TMP,  IX_QA,   IX_ZERO, IX_ZERO);
      6'd25: r = mk(OP_DOT, 1'b0, IX_P1,   IX_U0,   IX_F10,  IX_U1,   IX_F11);
      6'd26: r = mk(OP_DOT, 1'b0, IX_P2,   IX_U2,   IX_F00,  IX_U3,   IX_F01);
      6'd27: r = mk(OP_DOT, 1'b0, IX_TMP,  IX_U2,   IX_F10,  IX_U3,   IX_F11);
      6'd28: r = mk(OP_ADD, 1'b0, IX_P3,   IX_TMP,  IX_QR,   IX_ZERO, IX_ZERO);
      6'd29: r = mk(OP_SUB, 1'b0, IX_E0,   IX_Y0,   IX_X0,   IX_ZERO, IX_ZERO);
      6'd30: r = mk(OP_SUB, 1'b0, IX_E1,   IX_Y1,   IX_X1,   IX_ZERO, IX_ZERO);
      6'd31: r = mk(OP_DOT, 1'b0, IX_TMP,  IX_K0,   IX_E0,   IX_K1,   IX_E1);
      6'd32: r = mk(OP_ADD, 1'b0, IX_XU0,  IX_X0,   IX_TMP,  IX_ZERO, IX_ZERO);
      6'd33: r = mk(OP_DOT, 1'b0, IX_TMP,  IX_K2,   IX_E0,   IX_K3,   IX_E1);
      6'd34: r = mk(OP_ADD, 1'b0, IX_XU1,  IX_X1,   IX_TMP,  IX_ZERO, IX_ZERO);
      6'd35: r = mk(OP_DOT, 1'b0, IX_X0,   IX_F00,  IX_XU0,  IX_F01,  IX_XU1);
      6'd36: r = mk(OP_DOT, 1'b0, IX_X1,   IX_F10,  IX_XU0,  IX_F11,  IX_XU1);
      default: r = mk(OP_END, 1'b0, IX_TMP, IX_ZERO, IX_ZERO, IX_ZERO, IX_ZERO);
    endcase
    return r;
  endfunction

endpackage

[sv/kalman_filter_2state_core.sv]
// kalman_filter_2state_core: two-state (angle, rate) Kalman filter top level.
// Depends on kf2_pkg and kf2_div.
//
// Usage:
//  - Input channel in_valid/in_stall/in_data carries one beat per
//    measurement (angle and rate, signed Q8.24). in_stall is high while a
//    step runs or its result waits to load, or during the post-reset preload.
//  - Result channel out_valid/out_stall/out_data returns one beat per input:
//    the new estimate plus singular and saturated flags. The result sits in
//    an output register; the next measurement is taken while it waits.
//  - cfg_we/cfg_idx/cfg_wdata write F, Q and R. Indexes 8 and up are ignored.
//    The user must write only while the block is idle; it does not enforce it.
// Timing:
//  - A small sequencer walks a 37-entry microprogram through one shared
//    32x32 multiplier and one adder; each op fetches four operands through
//    a single-port scratch memory read.
//  - The four inverse entries use a bit-serial divider; a divide op waits
//    for it to finish before it writes back.
//  - One step runs at a time; the next input beat is taken only after the
//    result is loaded into the output register. A zero determinant ends the
//    step at the determinant op with the estimate unchanged.
// Reset: synchronous active low. Config and estimate return to defaults and
//  a preload writes the covariance entries into scratch; in_stall is high
//  during the preload. A stalled result holds in the output register and the
//  block parks with the next result until the register frees up.
module kalman_filter_2state_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kf2_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kf2_pkg::out_t     out_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata
);

  // phases of one microprogram op
  localparam logic [3:0] PH_A   = 4'd0;  // read a
  localparam logic [3:0] PH_B   = 4'd1;  // read b, latch a
  localparam logic [3:0] PH_C   = 4'd2;
  localparam logic [3:0] PH_D   = 4'd3;
  localparam logic [3:0] PH_DL  = 4'd4;  // latch d
  localparam logic [3:0] PH_M1  = 4'd5;  // a*b
  localparam logic [3:0] PH_M2  = 4'd6;  // c*d
  localparam logic [3:0] PH_RND = 4'd7;  // round / det difference
  localparam logic [3:0] PH_EX  = 4'd8;  // write back, latch det or start divide
  localparam logic [3:0] PH_WT  = 4'd9;  // det check, divider wait

  localparam logic signed [31:0] P00_INIT = 32'sd10349030;
  localparam logic signed [31:0] X0_INIT  = 32'sd13176795;
  localparam logic signed [31:0] ONE_Q24  = 32'sd16777216;
  localparam logic signed [64:0] HALF65   = 65'sd8388608;
  localparam logic signed [65:0] HALF66   = 66'sd8388608;

  kf2_pkg::state_t state_r, state_nxt;
  kf2_pkg::pc_t    pc_r, pc_nxt;
  logic [3:0]      ph_r, ph_nxt;
  logic [1:0]      init_cnt_r;

  // configuration
  logic signed [31:0] f00_r, f01_r, f10_r, f11_r;
  logic [30:0]        qa_r, qr_r, ra_r, rr_r;

  // filter state held in flops, measurement capture
  logic signed [31:0] x0_r, x1_r, y0_r, y1_r;
  logic               clip_r, sing_r;

  // scratch memory: covariance and temporaries
  logic signed [31:0] mem [32];
  logic signed [31:0] mem_q_r, ff_q_r;
  logic               rd_mem_r;
  logic               mem_we;
  logic [4:0]         mem_wa;
  logic signed [31:0] mem_wd;

  // shared datapath
  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic signed [63:0] prod_r, p1_r;
  logic signed [40:0] rnd_a_r, rnd_b_r;
  logic signed [64:0] dd_r;
  logic signed [41:0] det_r;
  logic               qneg_r;

  logic               out_valid_r;
  kf2_pkg::out_t      out_data_r;

  kf2_pkg::instr_t    instr;
  kf2_pkg::ix_t       rd_idx;
  logic signed [31:0] ff_val, opnd;
  logic               in_acc, out_load, fin, step_done, wr_en, det_zero;
  kf2_pkg::sat_t      ex_sat, div_sat, wr_sat;
  logic signed [64:0] rnd_a_t, rnd_b_t;
  logic signed [65:0] det_t;
  logic signed [32:0] adj;
  logic [32:0]        un;
  logic [41:0]        ud;
  logic               div_start, div_done;
  logic [kf2_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [kf2_pkg::DIV_DW-1:0] div_den;

  assign instr    = kf2_pkg::prog_rom(pc_r);
  assign det_zero = (det_r == '0);
  assign opnd     = rd_mem_r ? mem_q_r : ff_q_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kf2_pkg::ST_INIT: if (init_cnt_r == 2'd3) state_nxt = kf2_pkg::ST_IDLE;
      kf2_pkg::ST_IDLE: if (in_valid) state_nxt = kf2_pkg::ST_RUN;
      kf2_pkg::ST_RUN:  if (fin) state_nxt = kf2_pkg::ST_OUT;
      kf2_pkg::ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = kf2_pkg::ST_IDLE;
      default:          state_nxt = kf2_pkg::ST_INIT;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_stall  = (state_r != kf2_pkg::ST_IDLE);
    in_acc    = in_valid && (state_r == kf2_pkg::ST_IDLE);
    out_load  = (state_r == kf2_pkg::ST_OUT) && (!out_valid_r || !out_stall);
    fin       = 1'b0;
    step_done = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    if (state_r == kf2_pkg::ST_RUN) begin
      fin = ((ph_r == PH_A) && (instr.op == kf2_pkg::OP_END)) ||
            ((ph_r == PH_WT) && (instr.op == kf2_pkg::OP_DET) && det_zero);
      if ((ph_r == PH_EX) &&
          (instr.op inside {kf2_pkg::OP_ADD, kf2_pkg::OP_SUB, kf2_pkg::OP_DOT})) begin
        step_done = 1'b1;
        wr_en     = 1'b1;
      end
      if ((ph_r == PH_EX) && (instr.op == kf2_pkg::OP_DIV)) begin
        div_start = 1'b1;
      end
      if (ph_r == PH_WT) begin
        if ((instr.op == kf2_pkg::OP_DET) && !det_zero) begin
          step_done = 1'b1;
        end
        if ((instr.op == kf2_pkg::OP_DIV) && div_done) begin
          step_done = 1'b1;
          wr_en     = 1'b1;
        end
      end
    end

    pc_nxt = pc_r;
    ph_nxt = ph_r;
    if (in_acc) begin
      pc_nxt = '0;
      ph_nxt = PH_A;
    end else if (state_r == kf2_pkg::ST_RUN) begin
      if (step_done) begin
        pc_nxt = pc_r + 1'b1;
        ph_nxt = PH_A;
      end else if (!fin && (ph_r != PH_WT)) begin
        ph_nxt = ph_r + 1'b1;
      end
    end

    unique case (ph_r)
      PH_A:    rd_idx = instr.a;
      PH_B:    rd_idx = instr.b;
      PH_C:    rd_idx = instr.c;
      PH_D:    rd_idx = instr.d;
      default: rd_idx = instr.a;
    endcase
  end

  // flop-side operand select
  always_comb begin
    unique case (rd_idx)
      kf2_pkg::IX_F00:  ff_val = f00_r;
      kf2_pkg::IX_F01:  ff_val = f01_r;
      kf2_pkg::IX_F10:  ff_val = f10_r;
      kf2_pkg::IX_F11:  ff_val = f11_r;
      kf2_pkg::IX_QA:   ff_val = {1'b0, qa_r};
      kf2_pkg::IX_QR:   ff_val = {1'b0, qr_r};
      kf2_pkg::IX_RA:   ff_val = {1'b0, ra_r};
      kf2_pkg::IX_RR:   ff_val = {1'b0, rr_r};
      kf2_pkg::IX_Y0:   ff_val = y0_r;
      kf2_pkg::IX_Y1:   ff_val = y1_r;
      kf2_pkg::IX_ONE:  ff_val = ONE_Q24;
      kf2_pkg::IX_X0:   ff_val = x0_r;
      kf2_pkg::IX_X1:   ff_val = x1_r;
      default:          ff_val = '0;
    endcase
  end

  // arithmetic
  always_comb begin
    rnd_a_t = 65'(p1_r) + HALF65;
    rnd_b_t = 65'(prod_r) + HALF65;
    det_t   = 66'(dd_r) + HALF66;
    unique case (instr.op)
      kf2_pkg::OP_ADD: ex_sat = kf2_pkg::sat32(66'(a_r) + 66'(b_r));
      kf2_pkg::OP_SUB: ex_sat = kf2_pkg::sat32(66'(a_r) - 66'(b_r));
      kf2_pkg::OP_DOT: ex_sat = kf2_pkg::sat32(66'(rnd_a_r) + 66'(rnd_b_r));
      default:         ex_sat = kf2_pkg::sat32(66'(a_r));
    endcase
    div_sat = kf2_pkg::sat32(qneg_r ? -66'(div_quo) : 66'(div_quo));
    wr_sat  = (ph_r == PH_WT) ? div_sat : ex_sat;

    // n = +-adj * 2^24, d = det; q = (2|n| + |d|) / (2|d|)
    adj     = instr.neg ? -33'(a_r) : 33'(a_r);
    un      = adj[32] ? 33'(-adj) : 33'(adj);
    ud      = det_r[41] ? 42'(-det_r) : 42'(det_r);
    div_num = {un, 25'b0} + kf2_pkg::DIV_NW'(ud);
    div_den = {ud, 1'b0};

    if (state_r == kf2_pkg::ST_INIT) begin
      mem_we = 1'b1;
      mem_wa = {3'b0, init_cnt_r};
      mem_wd = (init_cnt_r == 2'd0) ? P00_INIT : '0;
    end else begin
      mem_we = wr_en && instr.dst[5];
      mem_wa = instr.dst[4:0];
      mem_wd = wr_sat.val;
    end
  end

  kf2_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kf2_pkg::ST_INIT;
      pc_r        <= '0;
      ph_r        <= PH_A;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      clip_r      <= 1'b0;
      sing_r      <= 1'b0;
      x0_r        <= X0_INIT;
      x1_r        <= '0;
      f00_r       <= 32'sd16777216;
      f01_r       <= 32'sd16777;
      f10_r       <= -32'sd397470;
      f11_r       <= 32'sd16776555;
      qa_r        <= 31'd17;
      qr_r        <= 31'd419;
      ra_r        <= 31'd335544;
      rr_r        <= 31'd838861;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ph_r    <= ph_nxt;
      if (state_r == kf2_pkg::ST_INIT) init_cnt_r <= init_cnt_r + 1'b1;

      if (cfg_we) begin
        unique case (cfg_idx)
          kf2_pkg::CFG_F00: f00_r <= cfg_wdata;
          kf2_pkg::CFG_F01: f01_r <= cfg_wdata;
          kf2_pkg::CFG_F10: f10_r <= cfg_wdata;
          kf2_pkg::CFG_F11: f11_r <= cfg_wdata;
          kf2_pkg::CFG_QA:  qa_r  <= cfg_wdata[30:0];
          kf2_pkg::CFG_QR:  qr_r  <= cfg_wdata[30:0];
          kf2_pkg::CFG_RA:  ra_r  <= cfg_wdata[30:0];
          kf2_pkg::CFG_RR:  rr_r  <= cfg_wdata[30:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        clip_r <= 1'b0;
        sing_r <= 1'b0;
      end else begin
        if (wr_en && wr_sat.clip) clip_r <= 1'b1;
        if (fin && (instr.op == kf2_pkg::OP_DET)) sing_r <= 1'b1;
      end
      if (wr_en && (instr.dst == kf2_pkg::IX_X0)) x0_r <= wr_sat.val;
      if (wr_en && (instr.dst == kf2_pkg::IX_X1)) x1_r <= wr_sat.val;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      y0_r <= in_data.meas_angle;
      y1_r <= in_data.meas_rate;
    end
    ff_q_r   <= ff_val;
    rd_mem_r <= rd_idx[5];
    unique case (ph_r)
      PH_B:    a_r <= opnd;
      PH_C:    b_r <= opnd;
      PH_D:    c_r <= opnd;
      PH_DL:   d_r <= opnd;
      PH_M1:   prod_r <= a_r * b_r;
      PH_M2: begin
        p1_r   <= prod_r;
        prod_r <= c_r * d_r;
      end
      PH_RND: begin
        rnd_a_r <= rnd_a_t[64:24];
        rnd_b_r <= rnd_b_t[64:24];
        dd_r    <= 65'(p1_r) - 65'(prod_r);
      end
      PH_EX: begin
        if (instr.op == kf2_pkg::OP_DET) det_r <= det_t[65:24];
        if (div_start) qneg_r <= adj[32] ^ det_r[41];
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r.est_angle <= x0_r;
      out_data_r.est_rate  <= x1_r;
      out_data_r.singular  <= sing_r;
      out_data_r.saturated <= clip_r & ~sing_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[rd_idx[4:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == kf2_pkg::ST_OUT))
    else $error("result appeared outside the output state");
  a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.singular |-> !out_data_r.saturated)
    else $error("singular result flagged saturated");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == kf2_pkg::ST_RUN) && (ph_r == PH_WT))
    else $error("divider finished outside its wait phase");
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kf2_pkg::ST_RUN) |-> (pc_r <= 6'd37))
    else $error("sequencer ran past the program end");

endmodule

[sv/kf2_div.sv]
// kf2_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on kf2_pkg for its widths.
module kf2_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [kf2_pkg::DIV_NW-1:0]    num,
  input  logic [kf2_pkg::DIV_DW-1:0]    den,
  output logic                          done,
  output logic [kf2_pkg::DIV_NW-1:0]    quo
);

  logic                          busy_r;
  logic                          done_r;
  logic [kf2_pkg::DIV_CW-1:0]    cnt_r;
  logic [kf2_pkg::DIV_DW-1:0]    rem_r;
  logic [kf2_pkg::DIV_NW-1:0]    quo_r;
  logic [kf2_pkg::DIV_DW-1:0]    den_r;
  logic [kf2_pkg::DIV_DW:0]      shifted;
  logic [kf2_pkg::DIV_DW:0]      diff;
  logic                          fits;

  assign shifted = {rem_r, quo_r[kf2_pkg::DIV_NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= kf2_pkg::DIV_CW'(kf2_pkg::DIV_NW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[kf2_pkg::DIV_DW-1:0] : shifted[kf2_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[kf2_pkg::DIV_NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without a finished run");
  a_busy_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(start)) else $error("divider busy without start");

endmodule

[tb/kalman_filter_2state_core_tb.sv]
`timescale 1ns / 1ps
// kalman_filter_2state_core_tb: self-checking bench for the two-state Kalman filter core.
// Holds its own fixed-point filter predictor; depends on kf2_pkg and the core RTL.
module kalman_filter_2state_core_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kf2_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kf2_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  kalman_filter_2state_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Filter predictor: its own copy of registers and state, all held in Q8.24.
  // ---------------------------------------------------------------------------
  localparam longint ONE = 64'sd16777216;
  logic signed [31:0] fm [4];     // transition matrix, row major
  logic [30:0] qa_r, qr_r, ra_r, rr_r;
  logic signed [31:0] x_est [2];
  logic signed [31:0] p_cov [4];
  bit clipped;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q16.48 -> Q8.24, round half up (arithmetic shift is a floor)
  function automatic longint round24(longint v);
    return (v + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [31:0] dot(logic signed [31:0] a, b, c, d);
    longint pa, pc;
    pa = longint'(a) * longint'(b);
    pc = longint'(c) * longint'(d);
    return clip32(round24(pa) + round24(pc));
  endfunction

  // n/d rounded to nearest, ties away from zero; 128-bit to keep 2n exact
  function automatic longint div_near(longint n, longint d);
    logic [127:0] un, ud, q;
    un = n < 0 ? 128'(-n) : 128'(n);
    ud = d < 0 ? 128'(-d) : 128'(d);
    q = (2 * un + ud) / (2 * ud);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void mat2(input logic signed [31:0] a [4],
                               input logic signed [31:0] b [4],
                               output logic signed [31:0] c [4]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        c[i*2+j] = dot(a[i*2], b[j], a[i*2+1], b[2+j]);
  endfunction

  task automatic filter_reset();
    fm[0] = 32'sd16777216; fm[1] = 32'sd16777; fm[2] = -32'sd397470; fm[3] = 32'sd16776555;
    qa_r = 31'd17; qr_r = 31'd419; ra_r = 31'd335544; rr_r = 31'd838861;
    x_est[0] = 32'sd13176795; x_est[1] = '0;
    p_cov[0] = 32'sd10349030; p_cov[1] = '0; p_cov[2] = '0; p_cov[3] = '0;
  endtask

  task automatic filter_write(input logic [3:0] idx, input logic [31:0] val);
    case (idx)
      kf2_pkg::CFG_F00: fm[0] = val;
      kf2_pkg::CFG_F01: fm[1] = val;
      kf2_pkg::CFG_F10: fm[2] = val;
      kf2_pkg::CFG_F11: fm[3] = val;
      kf2_pkg::CFG_QA:  qa_r = val[30:0];
      kf2_pkg::CFG_QR:  qr_r = val[30:0];
      kf2_pkg::CFG_RA:  ra_r = val[30:0];
      kf2_pkg::CFG_RR:  rr_r = val[30:0];
      default: ;
    endcase
  endtask

  function automatic kf2_pkg::out_t filter_step(kf2_pkg::in_t m);
    logic signed [31:0] s [4], iv [4], k [4], ik [4], t [4], u [4], v [4], ft [4];
    logic signed [31:0] e [2], xu [2], xn [2];
    longint det, adj [4];
    kf2_pkg::out_t r;
    clipped = 1'b0;
    s[0] = clip32(longint'(p_cov[0]) + longint'(ra_r));
    s[1] = p_cov[1];
    s[2] = p_cov[2];
    s[3] = clip32(longint'(p_cov[3]) + longint'(rr_r));
    det = round24(longint'(s[0]) * longint'(s[3]) - longint'(s[1]) * longint'(s[2]));
    if (det == 0) begin
      // singular innovation covariance: nothing moves
      r.est_angle = x_est[0];
      r.est_rate = x_est[1];
      r.singular = 1'b1;
      r.saturated = 1'b0;
      return r;
    end
    adj[0] = s[3]; adj[1] = -longint'(s[1]); adj[2] = -longint'(s[2]); adj[3] = s[0];
    for (int i = 0; i < 4; i++) iv[i] = clip32(div_near(adj[i] * ONE, det));
    mat2(p_cov, iv, k);
    ik[0] = clip32(ONE - k[0]);
    ik[1] = clip32(-longint'(k[1]));
    ik[2] = clip32(-longint'(k[2]));
    ik[3] = clip32(ONE - k[3]);
    ft[0] = fm[0]; ft[1] = fm[2]; ft[2] = fm[1]; ft[3] = fm[3];
    mat2(p_cov, ik, t);
    mat2(fm, t, u);
    mat2(u, ft, v);
    v[0] = clip32(longint'(v[0]) + longint'(qa_r));
    v[3] = clip32(longint'(v[3]) + longint'(qr_r));
    e[0] = clip32(longint'(m.meas_angle) - x_est[0]);
    e[1] = clip32(longint'(m.meas_rate) - x_est[1]);
    for (int i = 0; i < 2; i++)
      xu[i] = clip32(longint'(x_est[i]) + dot(k[i*2], e[0], k[i*2+1], e[1]));
    for (int i = 0; i < 2; i++)
      xn[i] = dot(fm[i*2], xu[0], fm[i*2+1], xu[1]);
    p_cov = v;
    x_est = xn;
    r.est_angle = xn[0];
    r.est_rate = xn[1];
    r.singular = 1'b0;
    r.saturated = clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat queues, knobs and bookkeeping
  // ---------------------------------------------------------------------------
  kf2_pkg::in_t  meas_q [$];     // measurements waiting for the driver
  kf2_pkg::out_t est_q [$];      // predicted estimates, oldest first
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;   // random idling enabled on both sides
  int hold_left = 0;    // receiver hold-off, counted in its own process
  bit hold_req = 1'b0;
  localparam int LIMIT = 3000000;

  // Driver: predicts at acceptance so config writes between phases line up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        est_q.insert(est_q.size(), filter_step(in_data));
        void'(meas_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (meas_q.size() > 0 && !(idle_on && $urandom_range(99) < 36)) begin
          in_valid <= 1'b1;
          in_data <= meas_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req && hold_left == 0) hold_left <= 4000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result beat and drives out_stall.
  always @(posedge clk) begin
    kf2_pkg::out_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (est_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          exp_r = est_q.pop_front();
          if (out_data.est_angle !== exp_r.est_angle) begin
            $display("%0t: est_angle expected %0d got %0d", $time, exp_r.est_angle,
                     out_data.est_angle);
            errors++;
          end
          if (out_data.est_rate !== exp_r.est_rate) begin
            $display("%0t: est_rate expected %0d got %0d", $time, exp_r.est_rate,
                     out_data.est_rate);
            errors++;
          end
          if (out_data.singular !== exp_r.singular) begin
            $display("%0t: singular expected %b got %b", $time, exp_r.singular,
                     out_data.singular);
            errors++;
          end
          if (out_data.saturated !== exp_r.saturated) begin
            $display("%0t: saturated expected %b got %b", $time, exp_r.saturated,
                     out_data.saturated);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 36);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("kalman_filter_2state_core_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rnd_meas();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(100000000)) - 32'sd50000000;
    endcase
  endfunction

  task automatic push_meas(input logic signed [31:0] a, input logic signed [31:0] b);
    kf2_pkg::in_t m;
    m.meas_angle = a;
    m.meas_rate = b;
    meas_q.insert(meas_q.size(), m);
  endtask

  // waits for the queue to drain, then the block's idle tail
  task automatic drain();
    while (meas_q.size() > 0 || in_valid || est_q.size() > 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    filter_write(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // F near identity with random perturbation, random Q and R
  task automatic cfg_plant(input int spread);
    cfg_write(kf2_pkg::CFG_F00, 32'sd16777216 + $signed($urandom_range(2*spread)) - spread);
    cfg_write(kf2_pkg::CFG_F01, $signed($urandom_range(2*spread)) - spread);
    cfg_write(kf2_pkg::CFG_F10, $signed($urandom_range(2*spread)) - spread);
    cfg_write(kf2_pkg::CFG_F11, 32'sd16777216 + $signed($urandom_range(2*spread)) - spread);
    cfg_write(kf2_pkg::CFG_QA, $urandom_range(100000));
    cfg_write(kf2_pkg::CFG_QR, $urandom_range(100000));
    cfg_write(kf2_pkg::CFG_RA, $urandom_range(1 << 22, 1));
    cfg_write(kf2_pkg::CFG_RR, $urandom_range(1 << 22, 1));
  endtask

  initial begin
    filter_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes at reset settings
    push_meas(32'sh7fffffff, 32'sh7fffffff);
    push_meas(32'sh80000000, 32'sh80000000);
    push_meas(32'sh7fffffff, 32'sh80000000);
    push_meas('0, '0);
    push_meas(32'sh55555555, 32'shaaaaaaaa);
    push_meas(32'shaaaaaaaa, 32'sh55555555);
    push_meas(32'sd13176795, 32'sd0);
    drain();

    // zero determinant: F = 0 sends P to Q, and with Q = 0 and R = 0 the next S is zero
    cfg_write(kf2_pkg::CFG_F00, '0);
    cfg_write(kf2_pkg::CFG_F01, '0);
    cfg_write(kf2_pkg::CFG_F10, '0);
    cfg_write(kf2_pkg::CFG_F11, '0);
    cfg_write(kf2_pkg::CFG_QA, '0);
    cfg_write(kf2_pkg::CFG_QR, '0);
    cfg_write(kf2_pkg::CFG_RA, '0);
    cfg_write(kf2_pkg::CFG_RR, '0);
    cfg_write(4'd9, 32'hffffffff);   // ignored index
    for (int i = 0; i < 4; i++) push_meas(rnd_meas(), rnd_meas());
    drain();

    // register extremes, top bit of q and r dropped
    cfg_write(kf2_pkg::CFG_F00, 32'sh7fffffff);
    cfg_write(kf2_pkg::CFG_F01, 32'sh80000000);
    cfg_write(kf2_pkg::CFG_F10, 32'sh7fffffff);
    cfg_write(kf2_pkg::CFG_F11, 32'sh80000000);
    cfg_write(kf2_pkg::CFG_QA, 32'hffffffff);
    cfg_write(kf2_pkg::CFG_QR, 32'h80000001);
    cfg_write(kf2_pkg::CFG_RA, 32'hffffffff);
    cfg_write(kf2_pkg::CFG_RR, 32'h7fffffff);
    cfg_write(4'd15, 32'h0);
    for (int i = 0; i < 6; i++) push_meas(rnd_meas(), rnd_meas());
    drain();

    // pressure: receiver holds off while the sender keeps offering
    cfg_plant(200000);
    hold_req <= 1'b1;
    for (int i = 0; i < 12; i++) push_meas(rnd_meas(), rnd_meas());
    repeat (20) @(posedge clk);
    hold_req <= 1'b0;
    drain();

    // random phases; one without idling
    for (int ph = 0; ph < 8; ph++) begin
      idle_on <= (ph != 3);
      if (ph == 5) cfg_plant(40000000);
      else cfg_plant(ph * 50000 + 1000);
      for (int i = 0; i < 180; i++) push_meas(rnd_meas(), rnd_meas());
      drain();
    end

    if (errors == 0) begin
      $display("kalman_filter_2state_core_tb: clean");
    end else begin
      $display("kalman_filter_2state_core_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/kf2_pkg.sv
sv/kf2_div.sv
sv/kalman_filter_2state_core.sv
tb/kalman_filter_2state_core_tb.sv
